// ===== rtl/length_prefixed_command_parser_macros.svh =====
// Assertion macros used by the checker file of the command parser.
`ifndef LENGTH_PREFIXED_COMMAND_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lpcp_pkg.sv =====
// Types, command tables and helpers of the length-prefixed command parser.
package lpcp_pkg;

  localparam int MAX_FRAME_DEF  = 65536;
  localparam int MAX_PARAMS_DEF = 10;
  localparam int NUM_CMDS       = 21;
  localparam int NAME_MAX       = 7;

  typedef enum logic [3:0] {
    PH_LEN   = 4'b0001,
    PH_NAME  = 4'b0010,
    PH_PARAM = 4'b0100,
    PH_PAY   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    EV_PARAM     = 2'd0,
    EV_PAYLOAD   = 2'd1,
    EV_FRAME_END = 2'd2
  } event_e;

  // Name bytes, first character at index 0.
  typedef logic [0:6][7:0] name_t;

  // Parameter format codes, one per format position.
  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_1B   = 2'd1;
  localparam logic [1:0] FMT_2B   = 2'd2;
  localparam logic [1:0] FMT_4B   = 2'd3;

  typedef logic [0:6][1:0] fmt_t;

  localparam name_t CMD_NAME [NUM_CMDS] = '{
    {"CALV", 24'h0}, {"CBYE", 24'h0}, {"CCLP", 24'h0}, {"CIAK", 24'h0},
    {"CINN", 24'h0}, {"CNOP", 24'h0}, {"COUT", 24'h0}, {"CROP", 24'h0},
    {"CSEC", 24'h0}, {"DCLP", 24'h0}, {"DINF", 24'h0}, {"DKDN", 24'h0},
    {"DKRP", 24'h0}, {"DKUP", 24'h0}, {"DMDN", 24'h0}, {"DMMV", 24'h0},
    {"DMUP", 24'h0}, {"DMWM", 24'h0}, {"DSOP", 24'h0}, {"QINF", 24'h0},
    {8'h53, 8'h79, 8'h6e, 8'h65, 8'h72, 8'h67, 8'h79}
  };

  localparam logic [2:0] CMD_NLEN [NUM_CMDS] = '{
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd7
  };

  localparam fmt_t CMD_FMT [NUM_CMDS] = '{
    {FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_1B,   FMT_4B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_2B,   FMT_2B,   FMT_4B,   FMT_2B,   FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_1B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_1B,   FMT_4B,   FMT_4B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_2B,   FMT_2B,   FMT_2B,   FMT_2B,   FMT_2B,   FMT_2B,   FMT_2B  },
    {FMT_2B,   FMT_2B,   FMT_2B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_2B,   FMT_2B,   FMT_2B,   FMT_2B,   FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_2B,   FMT_2B,   FMT_2B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_1B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_2B,   FMT_2B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_1B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_2B,   FMT_2B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_4B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE},
    {FMT_2B,   FMT_2B,   FMT_4B,   FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE}
  };

  // Results caused by one byte: window flush, one parameter or payload
  // byte, and a frame end, delivered in that order.
  typedef struct packed {
    logic [2:0]  flush_cnt;
    name_t       flush_bytes;
    logic        single_vld;
    event_e      single_ev;
    logic [4:0]  single_cmd;
    logic [3:0]  single_slot;
    logic [31:0] single_val;
    logic        end_vld;
    logic [4:0]  end_cmd;
    logic        end_tr;
    logic        end_ov;
  } bundle_t;

  // Format code of a command at a format position; none past the end.
  function automatic logic [1:0] fmt_code(input logic [4:0] cmd, input logic [2:0] pos);
    logic [4:0] idx;
    idx = cmd - 5'd1;
    if (cmd == 5'd0 || cmd > 5'(NUM_CMDS) || pos == 3'd7) begin
      return FMT_NONE;
    end
    return CMD_FMT[idx][pos];
  endfunction

  // Byte count of a parameter; strings travel as their 4-byte length.
  function automatic logic [2:0] due_of(input logic [1:0] code);
    case (code)
      FMT_1B:  return 3'd1;
      FMT_2B:  return 3'd2;
      default: return 3'd4;
    endcase
  endfunction

endpackage

// ===== rtl/lpcp_parser.sv =====
// Frame state and the per-byte parse step of the command parser.
module lpcp_parser #(
  parameter int MAX_FRAME  = lpcp_pkg::MAX_FRAME_DEF,
  parameter int MAX_PARAMS = lpcp_pkg::MAX_PARAMS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [7:0]        byte_i,
  output lpcp_pkg::bundle_t bundle_o
);

  localparam int BlW   = $clog2(MAX_FRAME + 1);
  localparam int SlotW = $clog2(MAX_PARAMS + 1);
  localparam logic [31:0]      MaxFrameW  = 32'(MAX_FRAME);
  localparam logic [BlW-1:0]   MaxFrameB  = BlW'(MAX_FRAME);
  localparam logic [SlotW-1:0] MaxParamsS = SlotW'(MAX_PARAMS);

  lpcp_pkg::phase_e   phase_q, phase_d;
  logic [31:0]        len_shift_q, len_shift_d;
  logic [1:0]         len_cnt_q, len_cnt_d;
  logic [BlW-1:0]     bytes_left_q, bytes_left_d;
  lpcp_pkg::name_t    win_q, win_d;
  logic [2:0]         fill_q, fill_d;
  logic [4:0]         cmd_q, cmd_d;
  logic [2:0]         fpos_q, fpos_d;
  logic [2:0]         due_q, due_d;
  logic [31:0]        acc_q, acc_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic               ovf_q, ovf_d;

  logic [31:0]           len_new;
  logic                  len_ovf;
  logic                  frame_byte;
  logic                  np_req;
  logic [1:0]            np_code;
  logic [2:0]            full_due;
  lpcp_pkg::name_t       win_nx;
  logic [2:0]            fill_nx;
  logic [lpcp_pkg::NUM_CMDS-1:0] pre_ok, full_hit, open_hit;
  logic [4:0]            hit_cmd;
  lpcp_pkg::bundle_t     bundle;

  // Name window with this byte added, so the match logic sees it.
  always_comb begin
    win_nx  = win_q;
    fill_nx = fill_q;
    if (phase_q == lpcp_pkg::PH_NAME && fill_q < 3'd7) begin
      win_nx[fill_q] = byte_i;
      fill_nx        = fill_q + 3'd1;
    end
  end

  // Prefix compare of the name window against the command table.
  always_comb begin
    for (int k = 0; k < lpcp_pkg::NUM_CMDS; k++) begin
      pre_ok[k] = 1'b1;
      for (int j = 0; j < lpcp_pkg::NAME_MAX; j++) begin
        if (3'(j) < fill_nx && win_nx[j] != lpcp_pkg::CMD_NAME[k][j]) begin
          pre_ok[k] = 1'b0;
        end
      end
      full_hit[k] = pre_ok[k] && (fill_nx == lpcp_pkg::CMD_NLEN[k]);
      open_hit[k] = pre_ok[k] && (fill_nx < lpcp_pkg::CMD_NLEN[k]);
    end
    hit_cmd = 5'd0;
    for (int k = lpcp_pkg::NUM_CMDS - 1; k >= 0; k--) begin
      if (full_hit[k]) begin
        hit_cmd = 5'(k + 1);
      end
    end
  end

  always_comb begin
    phase_d      = phase_q;
    len_shift_d  = len_shift_q;
    len_cnt_d    = len_cnt_q;
    bytes_left_d = bytes_left_q;
    win_d        = win_nx;
    fill_d       = fill_nx;
    cmd_d        = cmd_q;
    fpos_d       = fpos_q;
    due_d        = due_q;
    acc_d        = acc_q;
    slot_d       = slot_q;
    ovf_d        = ovf_q;
    bundle       = '0;
    frame_byte   = 1'b0;
    np_req       = 1'b0;
    np_code      = lpcp_pkg::FMT_NONE;
    full_due     = 3'd4;
    len_new      = {len_shift_q[23:0], byte_i};
    len_ovf      = len_new > MaxFrameW;

    case (phase_q)
      lpcp_pkg::PH_LEN: begin
        len_shift_d = len_new;
        len_cnt_d   = len_cnt_q + 2'd1;
        if (len_cnt_q == 2'd3) begin
          fill_d = 3'd0;
          cmd_d  = 5'd0;
          slot_d = '0;
          fpos_d = 3'd0;
          ovf_d  = len_ovf;
          if (len_new == 32'd0) begin
            bundle.end_vld = 1'b1;
            phase_d        = lpcp_pkg::PH_LEN;
            len_shift_d    = 32'd0;
            bytes_left_d   = '0;
            due_d          = 3'd0;
            acc_d          = 32'd0;
            ovf_d          = 1'b0;
          end else begin
            phase_d      = lpcp_pkg::PH_NAME;
            bytes_left_d = len_ovf ? MaxFrameB : len_new[BlW-1:0];
          end
        end
      end
      lpcp_pkg::PH_NAME: begin
        frame_byte = 1'b1;
        if (hit_cmd != 5'd0) begin
          cmd_d  = hit_cmd;
          fill_d = 3'd0;
          fpos_d = 3'd0;
          slot_d = '0;
          np_req = 1'b1;
        end else if (open_hit == '0) begin
          // No name can match any more: flush what was gathered.
          cmd_d              = 5'd0;
          bundle.flush_cnt   = fill_d;
          bundle.flush_bytes = win_d;
          fill_d             = 3'd0;
          phase_d            = lpcp_pkg::PH_PAY;
        end
      end
      lpcp_pkg::PH_PARAM: begin
        frame_byte = 1'b1;
        acc_d      = {acc_q[23:0], byte_i};
        due_d      = (due_q != 3'd0) ? due_q - 3'd1 : 3'd0;
        if (due_d == 3'd0) begin
          bundle.single_vld  = 1'b1;
          bundle.single_ev   = lpcp_pkg::EV_PARAM;
          bundle.single_cmd  = cmd_q;
          bundle.single_slot = 4'(slot_q);
          bundle.single_val  = acc_d;
          slot_d             = slot_q + 1'b1;
          fpos_d             = fpos_q + 3'd1;
          np_req             = 1'b1;
        end
      end
      lpcp_pkg::PH_PAY: begin
        frame_byte         = 1'b1;
        bundle.single_vld  = 1'b1;
        bundle.single_ev   = lpcp_pkg::EV_PAYLOAD;
        bundle.single_cmd  = cmd_q;
        bundle.single_val  = {24'd0, byte_i};
      end
      default: begin
        phase_d = lpcp_pkg::PH_LEN;
      end
    endcase

    // Open the next parameter of the format, or fall through to payload.
    if (np_req) begin
      np_code = lpcp_pkg::fmt_code(cmd_d, fpos_d);
      if (slot_d >= MaxParamsS || np_code == lpcp_pkg::FMT_NONE) begin
        phase_d = lpcp_pkg::PH_PAY;
      end else begin
        due_d   = lpcp_pkg::due_of(np_code);
        acc_d   = 32'd0;
        phase_d = lpcp_pkg::PH_PARAM;
      end
    end

    if (frame_byte) begin
      bytes_left_d = (bytes_left_q != '0) ? bytes_left_q - 1'b1 : '0;
      if (bytes_left_d == '0) begin
        bundle.end_vld = 1'b1;
        bundle.end_ov  = ovf_q;
        if (phase_d == lpcp_pkg::PH_NAME) begin
          bundle.flush_cnt   = fill_d;
          bundle.flush_bytes = win_d;
          cmd_d              = 5'd0;
          bundle.end_tr      = 1'b1;
        end else if (phase_d == lpcp_pkg::PH_PARAM) begin
          full_due      = lpcp_pkg::due_of(lpcp_pkg::fmt_code(cmd_d, fpos_d));
          bundle.end_tr = (due_d != 3'd0) && (due_d < full_due);
        end
        bundle.end_cmd = cmd_d;
        // Drop all frame state.
        phase_d     = lpcp_pkg::PH_LEN;
        len_shift_d = 32'd0;
        len_cnt_d   = 2'd0;
        fill_d      = 3'd0;
        cmd_d       = 5'd0;
        fpos_d      = 3'd0;
        due_d       = 3'd0;
        acc_d       = 32'd0;
        slot_d      = '0;
        ovf_d       = 1'b0;
      end
    end
  end

  assign bundle_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lpcp_pkg::PH_LEN;
      len_shift_q  <= 32'd0;
      len_cnt_q    <= 2'd0;
      bytes_left_q <= '0;
      fill_q       <= 3'd0;
      cmd_q        <= 5'd0;
      fpos_q       <= 3'd0;
      due_q        <= 3'd0;
      acc_q        <= 32'd0;
      slot_q       <= '0;
      ovf_q        <= 1'b0;
    end else if (advance_i) begin
      phase_q      <= phase_d;
      len_shift_q  <= len_shift_d;
      len_cnt_q    <= len_cnt_d;
      bytes_left_q <= bytes_left_d;
      fill_q       <= fill_d;
      cmd_q        <= cmd_d;
      fpos_q       <= fpos_d;
      due_q        <= due_d;
      acc_q        <= acc_d;
      slot_q       <= slot_d;
      ovf_q        <= ovf_d;
    end
  end

  // Name window holds data only; entries are read after they are written.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      win_q <= win_d;
    end
  end

endmodule

// ===== rtl/lpcp_emitter.sv =====
// Result register that hands out the results of one byte, one per cycle while out_ready_i is high.
module lpcp_emitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lpcp_pkg::bundle_t bundle_i,
  input  logic              out_ready_i,
  output logic              free_o,
  output logic              out_valid_o,
  output logic [1:0]        event_res_o,
  output logic [4:0]        command_o,
  output logic [3:0]        param_slot_o,
  output logic [31:0]       value_o,
  output logic              truncated_o,
  output logic              oversize_o
);

  lpcp_pkg::bundle_t bnd_q, bnd_d;
  logic [3:0]        rem;
  logic              take;

  assign rem = {1'b0, bnd_q.flush_cnt} + {3'd0, bnd_q.single_vld} + {3'd0, bnd_q.end_vld};
  assign out_valid_o = (rem != 4'd0);
  assign take        = out_valid_o && out_ready_i;
  assign free_o      = (rem == 4'd0) || (take && rem == 4'd1);

  always_comb begin
    event_res_o  = lpcp_pkg::EV_FRAME_END;
    command_o    = bnd_q.end_cmd;
    param_slot_o = 4'd0;
    value_o      = 32'd0;
    truncated_o  = bnd_q.end_tr;
    oversize_o   = bnd_q.end_ov;
    if (bnd_q.flush_cnt != 3'd0) begin
      event_res_o = lpcp_pkg::EV_PAYLOAD;
      command_o   = 5'd0;
      value_o     = {24'd0, bnd_q.flush_bytes[0]};
      truncated_o = 1'b0;
      oversize_o  = 1'b0;
    end else if (bnd_q.single_vld) begin
      event_res_o  = bnd_q.single_ev;
      command_o    = bnd_q.single_cmd;
      param_slot_o = bnd_q.single_slot;
      value_o      = bnd_q.single_val;
      truncated_o  = 1'b0;
      oversize_o   = 1'b0;
    end
  end

  always_comb begin
    bnd_d = bnd_q;
    if (take) begin
      if (bnd_q.flush_cnt != 3'd0) begin
        bnd_d.flush_cnt        = bnd_q.flush_cnt - 3'd1;
        bnd_d.flush_bytes[0:5] = bnd_q.flush_bytes[1:6];
      end else if (bnd_q.single_vld) begin
        bnd_d.single_vld = 1'b0;
      end else begin
        bnd_d.end_vld = 1'b0;
      end
    end
    if (load_i) begin
      bnd_d = bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_q <= '0;
    end else begin
      bnd_q <= bnd_d;
    end
  end

endmodule

// ===== rtl/length_prefixed_command_parser.sv =====
// Length-prefixed command parser: top level with the input byte register.
//
// Parses a received byte stream of frames, each a 4-byte big-endian length
// followed by that many bytes. A frame opens with one of 21 command names;
// the matched command's fixed format then yields big-endian parameters of
// 1, 2 or 4 bytes, each reported with its slot number, and every other frame
// byte comes out as a payload byte. A frame-end result closes every frame
// with the command number (0 if none matched) and the truncated and oversize
// flags. Lengths above MAX_FRAME are clamped and flagged. Throughput is one
// byte per clock as long as each byte causes at most one result and the
// result side is ready; results leave at one per clock while out_ready_i
// is high, so a byte causing more than one result holds the input side until
// they have all left (at most 8 results, when seven gathered name bytes are
// flushed on the last byte of a frame). A byte waits in the input register
// and passes through the parse step to the result register once that is free.
module length_prefixed_command_parser #(
  parameter int MAX_FRAME  = lpcp_pkg::MAX_FRAME_DEF,
  parameter int MAX_PARAMS = lpcp_pkg::MAX_PARAMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [4:0]  command_o,
  output logic [3:0]  param_slot_o,
  output logic [31:0] value_o,
  output logic        truncated_o,
  output logic        oversize_o
);

  logic              byte_vld_q, byte_vld_d;
  logic [7:0]        byte_q;
  logic              advance;
  logic              res_free;
  logic              in_fire;
  lpcp_pkg::bundle_t bundle;

  // Advance the held byte into the parser once the result register frees up.
  assign advance    = byte_vld_q && res_free;
  assign in_ready_o = !byte_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    byte_vld_d = byte_vld_q;
    if (in_fire) begin
      byte_vld_d = 1'b1;
    end else if (advance) begin
      byte_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else begin
      byte_vld_q <= byte_vld_d;
    end
  end

  // Hold the accepted byte; data only, no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= stream_byte_i;
    end
  end

  lpcp_parser #(
    .MAX_FRAME  (MAX_FRAME),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (byte_q),
    .bundle_o  (bundle)
  );

  // Drain the results of one byte, one transaction per cycle while out_ready_i is high.
  lpcp_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .bundle_i     (bundle),
    .out_ready_i  (out_ready_i),
    .free_o       (res_free),
    .out_valid_o  (out_valid_o),
    .event_res_o  (event_res_o),
    .command_o    (command_o),
    .param_slot_o (param_slot_o),
    .value_o      (value_o),
    .truncated_o  (truncated_o),
    .oversize_o   (oversize_o)
  );

endmodule

// ===== rtl/lpcp_checker.sv =====
// Port-level checks of the command parser, bound to the top level.
`include "length_prefixed_command_parser_macros.svh"

module lpcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  stream_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  event_res_o,
  input logic [4:0]  command_o,
  input logic [3:0]  param_slot_o,
  input logic [31:0] value_o,
  input logic        truncated_o,
  input logic        oversize_o
);

  `LPCP_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(event_res_o) && $stable(value_o) && $stable(command_o), "stalled result changed")
  `LPCP_ASSERT_IMP(a_flags_end_only, out_valid_o && event_res_o != lpcp_pkg::EV_FRAME_END, !truncated_o && !oversize_o, "flags outside frame end")
  `LPCP_ASSERT_IMP(a_slot_param_only, out_valid_o && event_res_o != lpcp_pkg::EV_PARAM, param_slot_o == 4'd0, "slot outside parameter")
  `LPCP_ASSERT_IMP(a_param_has_cmd, out_valid_o && event_res_o == lpcp_pkg::EV_PARAM, command_o != 5'd0, "parameter without command")
  `LPCP_ASSERT_IMP(a_end_no_value, out_valid_o && event_res_o == lpcp_pkg::EV_FRAME_END, value_o == 32'd0, "frame end with value")

endmodule

bind length_prefixed_command_parser lpcp_checker u_lpcp_checker (.*);

// ===== tb/tb_length_prefixed_command_parser.sv =====
// Self-checking testbench for the length-prefixed command parser.
module tb_length_prefixed_command_parser;
  import lpcp_pkg::*;

  localparam int MAX_FRAME   = MAX_FRAME_DEF;
  localparam int PARAM_LIMIT = MAX_PARAMS_DEF;
  localparam logic [4:0] NO_COMMAND = 5'd0;

  // Command names in table order, first character at index 0. The last entry
  // is the only seven-character name, spelled out byte by byte.
  localparam logic [0:6][7:0] CMD_TEXT [NUM_CMDS] = '{
    {"CALV", 24'h0}, {"CBYE", 24'h0}, {"CCLP", 24'h0}, {"CIAK", 24'h0},
    {"CINN", 24'h0}, {"CNOP", 24'h0}, {"COUT", 24'h0}, {"CROP", 24'h0},
    {"CSEC", 24'h0}, {"DCLP", 24'h0}, {"DINF", 24'h0}, {"DKDN", 24'h0},
    {"DKRP", 24'h0}, {"DKUP", 24'h0}, {"DMDN", 24'h0}, {"DMMV", 24'h0},
    {"DMUP", 24'h0}, {"DMWM", 24'h0}, {"DSOP", 24'h0}, {"QINF", 24'h0},
    {8'h53, 8'h79, 8'h6e, 8'h65, 8'h72, 8'h67, 8'h79}
  };

  localparam logic [2:0] CMD_LEN [NUM_CMDS] = '{
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd7
  };

  // Parameter layout per command: '1', '2' and '4' are byte counts, 'S' is a
  // string carried as its 4-byte length, a zero byte ends the layout.
  localparam logic [0:6][7:0] CMD_LAYOUT [NUM_CMDS] = '{
    56'h0, 56'h0, {"14", 40'h0}, 56'h0, {"2242", 24'h0}, 56'h0, 56'h0, 56'h0,
    {"1", 48'h0}, {"14S", 32'h0}, "2222222", {"222", 32'h0}, {"2222", 24'h0},
    {"222", 32'h0}, {"1", 48'h0}, {"22", 40'h0}, {"1", 48'h0}, {"22", 40'h0},
    {"S", 48'h0}, 56'h0, {"22S", 32'h0}
  };

  typedef struct packed {
    event_e      ev;
    logic [4:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] val;
    logic        trunc;
    logic        over;
  } parse_result_t;

  typedef struct {
    logic [7:0] data;
    bit         wait_drain;   // hold this byte back until all results are in
  } stim_byte_t;

  typedef enum {FR_WELL, FR_CUT, FR_JUNK, FR_EMPTY} frame_kind_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i = 8'h0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [1:0]  event_res_o;
  logic [4:0]  command_o;
  logic [3:0]  param_slot_o;
  logic [31:0] value_o;
  logic        truncated_o;
  logic        oversize_o;

  length_prefixed_command_parser i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .stream_byte_i,
    .out_valid_o,
    .out_ready_i,
    .event_res_o,
    .command_o,
    .param_slot_o,
    .value_o,
    .truncated_o,
    .oversize_o
  );

  always #5 clk_i = ~clk_i;

  stim_byte_t    byte_feed_q[$];
  parse_result_t parsed_events_q[$];
  logic [7:0]    frame_body[$];
  stim_byte_t    next_in;
  parse_result_t want;
  int unsigned   cycle_cnt    = 0;
  int unsigned   cycle_limit  = 32'hFFFF_FFFF;
  int unsigned   mismatch_cnt = 0;

  // Parser state as the expected-result side sees it.
  phase_e          frm_phase;
  logic [31:0]     len_word;
  logic [2:0]      len_seen;
  logic [16:0]     frame_left;
  logic [0:6][7:0] name_buf;
  logic [2:0]      name_cnt;
  logic [4:0]      cur_cmd;
  logic [2:0]      fmt_idx;
  logic [2:0]      param_left;
  logic [31:0]     param_acc;
  logic [3:0]      slot_idx;
  logic            frame_over;

  // ---------------------------------------------------------------------------
  // Expected-result computation
  // ---------------------------------------------------------------------------

  function automatic logic [2:0] layout_bytes(input logic [7:0] c);
    if (c == "1") return 3'd1;
    if (c == "2") return 3'd2;
    return 3'd4;
  endfunction

  // Layout character of a command at a position; zero past the layout end.
  function automatic logic [7:0] layout_char(input logic [4:0] cmd, input logic [2:0] pos);
    if (cmd == NO_COMMAND || cmd > 5'(NUM_CMDS) || pos == 3'd7) return 8'h0;
    return CMD_LAYOUT[cmd - 5'd1][pos];
  endfunction

  function automatic void push_result(input event_e ev, input logic [4:0] cmd,
                                      input logic [3:0] slot, input logic [31:0] val,
                                      input logic trunc, input logic over);
    parsed_events_q.push_back('{ev, cmd, slot, val, trunc, over});
  endfunction

  function automatic void clear_frame_state();
    frm_phase  = PH_LEN;
    len_word   = '0;
    len_seen   = '0;
    frame_left = '0;
    name_cnt   = '0;
    cur_cmd    = NO_COMMAND;
    fmt_idx    = '0;
    param_left = '0;
    param_acc  = '0;
    slot_idx   = '0;
    frame_over = 1'b0;
  endfunction

  // Open the next parameter of the layout, or fall through to payload.
  function automatic void start_next_param();
    logic [7:0] c;
    c = layout_char(cur_cmd, fmt_idx);
    if (c == 8'h0 || slot_idx >= PARAM_LIMIT) begin
      frm_phase = PH_PAY;
    end else begin
      param_left = layout_bytes(c);
      param_acc  = '0;
      frm_phase  = PH_PARAM;
    end
  endfunction

  // Release the gathered name bytes as payload of no command.
  function automatic void spill_name();
    for (int i = 0; i < 7; i++) begin
      if (i < name_cnt) push_result(EV_PAYLOAD, NO_COMMAND, 4'd0, {24'h0, name_buf[i]}, 0, 0);
    end
    name_cnt = '0;
  endfunction

  function automatic bit name_prefix_match(input int k);
    for (int i = 0; i < 7; i++) begin
      if (i < name_cnt && name_buf[i] != CMD_TEXT[k][i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void parse_stream_byte(input logic [7:0] b);
    bit         hit;
    bit         alive;
    bit         cut;
    logic [2:0] full_len;
    hit   = 1'b0;
    alive = 1'b0;
    cut   = 1'b0;
    if (frm_phase == PH_LEN) begin
      len_word = {len_word[23:0], b};
      len_seen = len_seen + 3'd1;
      if (len_seen < 3'd4) return;
      // Clamp long frames; the bytes past the clamp start the next length.
      frame_over = len_word > 32'(MAX_FRAME);
      frame_left = frame_over ? 17'(MAX_FRAME) : len_word[16:0];
      len_seen   = '0;
      name_cnt   = '0;
      cur_cmd    = NO_COMMAND;
      slot_idx   = '0;
      fmt_idx    = '0;
      if (frame_left == '0) begin
        push_result(EV_FRAME_END, NO_COMMAND, 4'd0, 32'd0, 0, 0);
        clear_frame_state();
      end else begin
        frm_phase = PH_NAME;
      end
      return;
    end

    if (frame_left != '0) frame_left = frame_left - 17'd1;

    case (frm_phase)
      PH_NAME: begin
        if (name_cnt < 3'd7) begin
          name_buf[name_cnt] = b;
          name_cnt = name_cnt + 3'd1;
        end
        // First full match in table order wins.
        for (int k = 0; k < NUM_CMDS; k++) begin
          if (!hit && name_cnt == CMD_LEN[k] && name_prefix_match(k)) begin
            hit = 1'b1;
            cur_cmd = 5'(k + 1);
          end
        end
        if (hit) begin
          name_cnt = '0;
          fmt_idx  = '0;
          slot_idx = '0;
          start_next_param();
        end else begin
          for (int k = 0; k < NUM_CMDS; k++) begin
            if (name_cnt < CMD_LEN[k] && name_prefix_match(k)) alive = 1'b1;
          end
          if (!alive) begin
            cur_cmd = NO_COMMAND;
            spill_name();
            frm_phase = PH_PAY;
          end
        end
      end
      PH_PARAM: begin
        param_acc = {param_acc[23:0], b};
        if (param_left != '0) param_left = param_left - 3'd1;
        if (param_left == '0) begin
          push_result(EV_PARAM, cur_cmd, slot_idx, param_acc, 0, 0);
          slot_idx = slot_idx + 4'd1;
          fmt_idx  = fmt_idx + 3'd1;
          start_next_param();
        end
      end
      default: begin
        push_result(EV_PAYLOAD, cur_cmd, 4'd0, {24'h0, b}, 0, 0);
      end
    endcase

    if (frame_left == '0) begin
      if (frm_phase == PH_NAME) begin
        // Frame ran out while a name could still match.
        spill_name();
        cur_cmd = NO_COMMAND;
        cut = 1'b1;
      end else if (frm_phase == PH_PARAM) begin
        // Only a partly received parameter counts as truncation.
        full_len = layout_bytes(layout_char(cur_cmd, fmt_idx));
        cut = param_left != '0 && param_left < full_len;
      end
      push_result(EV_FRAME_END, cur_cmd, 4'd0, 32'd0, cut, frame_over);
      clear_frame_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  // Lean on the all-zeros and all-ones bytes, otherwise uniform.
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Well-formed body: name, every parameter of its layout, a few payload bytes.
  function automatic void build_command_body(input int k);
    logic [7:0] c;
    frame_body.delete();
    for (int i = 0; i < CMD_LEN[k]; i++) frame_body.push_back(CMD_TEXT[k][i]);
    for (int p = 0; p < 7; p++) begin
      c = CMD_LAYOUT[k][p];
      if (c == 8'h0) break;
      repeat (layout_bytes(c)) frame_body.push_back(any_byte());
    end
    repeat ($urandom_range(0, 3)) frame_body.push_back(any_byte());
  endfunction

  // Append a length prefix and the body to the feed, then empty the body.
  function automatic void queue_frame(input logic [31:0] declared, input bit drain);
    for (int i = 0; i < 4; i++) begin
      byte_feed_q.push_back('{declared[31 - 8 * i -: 8], drain && i == 0});
    end
    foreach (frame_body[i]) byte_feed_q.push_back('{frame_body[i], 1'b0});
    frame_body.delete();
  endfunction

  // Random stall for either side, with a quiet window that runs at full rate.
  function automatic bit take_break();
    if (cycle_cnt >= 150 && cycle_cnt < 400) return 1'b0;
    return $urandom_range(0, 99) < 16;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      // Cap the report so a badly broken build still leaves a readable log.
      if (mismatch_cnt < 200) $error("%s: expected %0h, actual %0h", field, want_v, got_v);
      mismatch_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the next byte when the input slot is free and no break or drain
  // wait holds it back; predict the results of each byte at the edge that takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) parse_stream_byte(stream_byte_i);
      // Hold valid and payload until the transaction goes through.
      if (!in_valid_i || in_ready_o) begin
        if (byte_feed_q.size() != 0 && !take_break() &&
            !(byte_feed_q[0].wait_drain && parsed_events_q.size() != 0)) begin
          next_in = byte_feed_q.pop_front();
          in_valid_i    <= 1'b1;
          stream_byte_i <= next_in.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the result side at random and match each result against
  // the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !take_break();
      if (out_valid_o && out_ready_i) begin
        if (parsed_events_q.size() == 0) begin
          $error("result with nothing expected: event_res %0d command %0d value %0h",
                 event_res_o, command_o, value_o);
          mismatch_cnt++;
        end else begin
          want = parsed_events_q.pop_front();
          check_field("event_res", 32'(want.ev), 32'(event_res_o));
          check_field("command", 32'(want.cmd), 32'(command_o));
          check_field("param_slot", 32'(want.slot), 32'(param_slot_o));
          check_field("value", want.val, value_o);
          check_field("truncated", 32'(want.trunc), 32'(truncated_o));
          check_field("oversize", 32'(want.over), 32'(oversize_o));
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == cycle_limit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the whole feed, release reset, wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin
    frame_kind_e kind;
    int          k;
    int          frames;
    int          roll;
    int          cut_len;
    int          prefix_len;
    bit          drain;

    clear_frame_state();
    frames = 0;

    // Directed: empty frame.
    queue_frame(32'd0, 1'b0);
    // Frame ends inside a name that could still match.
    frame_body = '{"D", "K", "R"};
    queue_frame(32'd3, 1'b0);
    // Full one-byte parameter, then a four-byte one cut after its first byte;
    // hold it back until the frames above have fully come out.
    frame_body = '{"C", "C", "L", "P", 8'hFF, 8'h80};
    queue_frame(32'd6, 1'b1);
    // No name can match from the first byte on.
    frame_body = '{8'h00};
    queue_frame(32'd1, 1'b0);

    // Random frames: every command once well formed, then a mix.
    while (frames < NUM_CMDS || byte_feed_q.size() < 420) begin
      drain = (frames % 9 == 4);
      roll  = $urandom_range(0, 99);
      kind  = (frames < NUM_CMDS || roll < 50) ? FR_WELL :
              (roll < 75) ? FR_CUT : (roll < 90) ? FR_JUNK : FR_EMPTY;
      k     = (frames < NUM_CMDS) ? frames : $urandom_range(0, NUM_CMDS - 1);
      case (kind)
        FR_WELL: begin
          build_command_body(k);
        end
        FR_CUT: begin
          // End the frame anywhere: in the name, in a parameter, between them.
          build_command_body(k);
          cut_len = $urandom_range(1, frame_body.size() - 1);
          while (frame_body.size() > cut_len) void'(frame_body.pop_back());
        end
        FR_JUNK: begin
          // Start like a real name, then diverge; often the long name, one
          // byte short of complete.
          frame_body.delete();
          if ($urandom_range(0, 2) == 0) begin
            k = NUM_CMDS - 1;
            prefix_len = 6;
          end else begin
            prefix_len = $urandom_range(0, CMD_LEN[k] - 1);
          end
          for (int i = 0; i < prefix_len; i++) frame_body.push_back(CMD_TEXT[k][i]);
          repeat ($urandom_range(1, 5)) frame_body.push_back(any_byte());
        end
        default: begin
          frame_body.delete();
        end
      endcase
      queue_frame(32'(frame_body.size()), drain);
      frames++;
    end

    // Several times the slowest plausible run, including full result stalls.
    cycle_limit = 24 * byte_feed_q.size() + 20000;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_feed_q.size() != 0 || in_valid_i || parsed_events_q.size() != 0) begin
      @(posedge clk_i);
    end
    // Let any stray result show up before the verdict.
    repeat (16) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lpcp_pkg.sv
rtl/lpcp_parser.sv
rtl/lpcp_emitter.sv
rtl/length_prefixed_command_parser.sv
rtl/lpcp_checker.sv
tb/tb_length_prefixed_command_parser.sv
